// ===== hdl/spt_pkg.sv =====
`timescale 1ns / 1ps

package spt_pkg;

    // Default table depths.
    localparam int SEG_TABLE_DEPTH_DEF  = 256;
    localparam int PAGE_TABLE_DEPTH_DEF = 1024;

    // Field widths of the request and response words.
    localparam int ACTION_W   = 3;
    localparam int SLOT_W     = 10;
    localparam int DATA_W     = 64;
    localparam int SELECTOR_W = 16;
    localparam int OFFSET_W   = 32;
    localparam int ADDR_W     = 32;
    localparam int STATUS_W   = 3;

    // The selector carries a 13-bit table index in bits 3 to 15.
    localparam int SEG_IDX_W = 13;

    // Configuration port.
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 11;
    localparam int SEG_CNT_W   = 9;
    localparam int PAGE_CNT_W  = 11;

    localparam logic [CFG_INDEX_W-1:0] CFG_GLOBAL_ENTRIES    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_LOCAL_ENTRIES     = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_DIRECTORY_ENTRIES = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_PAGETAB_ENTRIES   = 2'd3;

    // Action codes of a request word.
    localparam logic [ACTION_W-1:0] ACT_TRANSLATE = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_WR_GLOBAL = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_WR_LOCAL  = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_WR_DIR    = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_WR_PTE    = 3'd4;

    // Depth of the command queue between front and back end.
    localparam int QUEUE_DEPTH = 2;

    // Page table entry as stored: frame and present bit.
    localparam int PTE_W = 21;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK          = 3'd0,
        ST_NULL        = 3'd1,
        ST_NOSEG       = 3'd2,
        ST_ABSENT      = 3'd3,
        ST_LIMIT       = 3'd4,
        ST_NOPAGE      = 3'd5,
        ST_PAGE_ABSENT = 3'd6
    } status_t;

    typedef enum logic [2:0] {
        K_NOP,
        K_TRANSLATE,
        K_WR_GLOBAL,
        K_WR_LOCAL,
        K_WR_DIR,
        K_WR_PTE
    } cmd_kind_t;

    // Classified command handed from the front end to the back end.
    typedef struct packed {
        cmd_kind_t              kind;
        logic                   is_local;
        logic [SEG_IDX_W-1:0]   seg_idx;
        logic [SLOT_W-1:0]      slot;
        logic [DATA_W-1:0]      data;
        logic [OFFSET_W-1:0]    offset;
        status_t                early;
    } cmd_t;

    // Configuration register set.
    typedef struct packed {
        logic [SEG_CNT_W-1:0]  global_entries;
        logic [SEG_CNT_W-1:0]  local_entries;
        logic [PAGE_CNT_W-1:0] directory_entries;
        logic [PAGE_CNT_W-1:0] pagetab_entries;
    } cfg_t;

endpackage

// ===== hdl/spt_req_if.sv =====
`timescale 1ns / 1ps

interface spt_req_if;
    import spt_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [ACTION_W-1:0]   action;
    logic [SLOT_W-1:0]     entry_index;
    logic [DATA_W-1:0]     entry_data;
    logic [SELECTOR_W-1:0] selector;
    logic [OFFSET_W-1:0]   offset;

    modport source (
        output valid, action, entry_index, entry_data, selector, offset,
        input  ready
    );

    modport sink (
        input  valid, action, entry_index, entry_data, selector, offset,
        output ready
    );
endinterface

// ===== hdl/spt_rsp_if.sv =====
`timescale 1ns / 1ps

interface spt_rsp_if;
    import spt_pkg::*;

    logic                valid;
    logic                ready;
    logic [ADDR_W-1:0]   phys_addr;
    logic [STATUS_W-1:0] status;

    modport source (
        output valid, phys_addr, status,
        input  ready
    );

    modport sink (
        input  valid, phys_addr, status,
        output ready
    );
endinterface

// ===== hdl/spt_ram.sv =====
`timescale 1ns / 1ps

module spt_ram #(
    parameter int DATA_WIDTH = 8,
    parameter int DEPTH      = 16,
    parameter int ADDR_WIDTH = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                  clk,
    input  logic                  wr_en,
    input  logic [ADDR_WIDTH-1:0] wr_addr,
    input  logic [DATA_WIDTH-1:0] wr_data,
    input  logic                  rd_en,
    input  logic [ADDR_WIDTH-1:0] rd_addr,
    output logic [DATA_WIDTH-1:0] rd_data
);
    logic [DATA_WIDTH-1:0] mem_reg [DEPTH];
    logic [DATA_WIDTH-1:0] rd_data_reg;

    // One write port, one registered read port; read data holds between reads.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
endmodule

// ===== hdl/spt_front.sv =====
`timescale 1ns / 1ps

module spt_front #(
    parameter int SEG_TABLE_DEPTH  = spt_pkg::SEG_TABLE_DEPTH_DEF,
    parameter int PAGE_TABLE_DEPTH = spt_pkg::PAGE_TABLE_DEPTH_DEF
) (
    spt_req_if.sink        req,
    input  spt_pkg::cfg_t  cfg,
    input  logic           q_full,
    output logic           push,
    output spt_pkg::cmd_t  cmd
);
    import spt_pkg::*;

    localparam int SEG_CMP_W  = SEG_IDX_W + 1;
    localparam int PAGE_CMP_W = SLOT_W + 1;

    logic                  sel_local;
    logic [SEG_IDX_W-1:0]  sel_idx;
    logic [SEG_CNT_W-1:0]  seg_count;
    logic                  null_sel;
    logic                  no_seg;
    logic                  seg_slot_ok;
    logic                  page_slot_ok;

    // A word is taken whenever the queue has room.
    assign req.ready = !q_full;
    assign push      = req.valid && !q_full;

    // Selector decode and the checks that need only the counts.
    assign sel_local = req.selector[2];
    assign sel_idx   = req.selector[SELECTOR_W-1:3];
    assign seg_count = sel_local ? cfg.local_entries : cfg.global_entries;
    assign null_sel  = !sel_local && (sel_idx == '0);
    assign no_seg    = ({{(SEG_CMP_W-SEG_CNT_W){1'b0}}, seg_count} <= {1'b0, sel_idx})
                    || ({1'b0, sel_idx} >= SEG_CMP_W'(SEG_TABLE_DEPTH));

    // Load slots beyond the table depth are dropped.
    assign seg_slot_ok  = {{(SEG_CMP_W-SLOT_W){1'b0}}, req.entry_index}
                        < SEG_CMP_W'(SEG_TABLE_DEPTH);
    assign page_slot_ok = {1'b0, req.entry_index} < PAGE_CMP_W'(PAGE_TABLE_DEPTH);

    // Classify the word into a back-end command.
    always_comb
    begin
        cmd.is_local = sel_local;
        cmd.seg_idx  = sel_idx;
        cmd.slot     = req.entry_index;
        cmd.data     = req.entry_data;
        cmd.offset   = req.offset;
        cmd.early    = ST_OK;
        cmd.kind     = K_NOP;
        case (req.action)
            ACT_TRANSLATE:
            begin
                cmd.kind = K_TRANSLATE;
                if (null_sel)
                begin
                    cmd.early = ST_NULL;
                end
                else if (no_seg)
                begin
                    cmd.early = ST_NOSEG;
                end
            end
            ACT_WR_GLOBAL: cmd.kind = seg_slot_ok  ? K_WR_GLOBAL : K_NOP;
            ACT_WR_LOCAL:  cmd.kind = seg_slot_ok  ? K_WR_LOCAL  : K_NOP;
            ACT_WR_DIR:    cmd.kind = page_slot_ok ? K_WR_DIR    : K_NOP;
            ACT_WR_PTE:    cmd.kind = page_slot_ok ? K_WR_PTE    : K_NOP;
            default:       cmd.kind = K_NOP;
        endcase
    end
endmodule

// ===== hdl/spt_queue.sv =====
`timescale 1ns / 1ps

module spt_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  spt_pkg::cmd_t  push_cmd,
    output logic           full,
    input  logic           pop,
    output logic           head_valid,
    output spt_pkg::cmd_t  head_cmd
);
    import spt_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t             entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full       = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = entry_reg[rd_ptr_reg];

    // Pointer and fill level update.
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end
endmodule

// ===== hdl/spt_back.sv =====
`timescale 1ns / 1ps

module spt_back #(
    parameter int SEG_TABLE_DEPTH  = spt_pkg::SEG_TABLE_DEPTH_DEF,
    parameter int PAGE_TABLE_DEPTH = spt_pkg::PAGE_TABLE_DEPTH_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  spt_pkg::cfg_t  cfg,
    input  logic           q_valid,
    input  spt_pkg::cmd_t  q_cmd,
    output logic           q_pop,
    spt_rsp_if.source      rsp
);
    import spt_pkg::*;

    localparam int SEG_AW  = (SEG_TABLE_DEPTH > 1) ? $clog2(SEG_TABLE_DEPTH) : 1;
    localparam int PAGE_AW = (PAGE_TABLE_DEPTH > 1) ? $clog2(PAGE_TABLE_DEPTH) : 1;

    typedef enum logic [3:0] {
        BK_IDLE = 4'b0001,
        BK_DESC = 4'b0010,
        BK_PAGE = 4'b0100,
        BK_WALK = 4'b1000
    } bk_state_t;

    bk_state_t             state_reg, state_next;
    logic                  local_reg, local_next;
    logic [OFFSET_W-1:0]   offset_reg, offset_next;
    logic [ADDR_W-1:0]     lin_reg, lin_next;
    logic                  out_valid_reg, out_valid_next;
    logic [ADDR_W-1:0]     phys_reg, phys_next;
    status_t               status_reg, status_next;

    logic                  out_free;
    logic                  out_load;

    // Memory ports.
    logic                  g_we, l_we, d_we, p_we;
    logic                  g_re, l_re, d_re, p_re;
    logic [SEG_IDX_W-1:0]  slot_ext;
    logic [SEG_AW-1:0]     seg_wr_addr, seg_rd_addr;
    logic [PAGE_AW-1:0]    page_wr_addr, dir_rd_addr, tab_rd_addr;
    logic [DATA_W-1:0]     g_rdata, l_rdata;
    logic                  d_rdata;
    logic [PTE_W-1:0]      p_rdata, pte_wdata;

    // Descriptor fields and linear address.
    logic [DATA_W-1:0]     desc;
    logic [19:0]           limit_raw;
    logic [ADDR_W-1:0]     limit;
    logic [ADDR_W-1:0]     base;
    logic [ADDR_W-1:0]     lin_sum;
    logic                  over_limit;
    logic [9:0]            dir_idx, tab_idx;
    logic                  dir_bad, tab_bad;

    assign out_free = !out_valid_reg || rsp.ready;

    assign slot_ext     = {{(SEG_IDX_W-SLOT_W){1'b0}}, q_cmd.slot};
    assign seg_wr_addr  = slot_ext[SEG_AW-1:0];
    assign seg_rd_addr  = q_cmd.seg_idx[SEG_AW-1:0];
    assign page_wr_addr = q_cmd.slot[PAGE_AW-1:0];
    assign pte_wdata    = {q_cmd.data[31:12], q_cmd.data[0]};

    // Descriptor decode: limit with optional 4K scaling, base, bounds check.
    assign desc       = local_reg ? l_rdata : g_rdata;
    assign limit_raw  = {desc[51:48], desc[15:0]};
    assign limit      = desc[55] ? {limit_raw, 12'hFFF} : {12'h000, limit_raw};
    assign base       = {desc[63:56], desc[39:32], desc[31:16]};
    assign lin_sum    = base + offset_reg;
    assign over_limit = offset_reg > limit;

    // Directory and table indexes checked against their counts.
    assign dir_idx     = lin_reg[31:22];
    assign tab_idx     = lin_reg[21:12];
    assign dir_bad     = ({1'b0, dir_idx} >= cfg.directory_entries)
                      || ({1'b0, dir_idx} >= PAGE_CNT_W'(PAGE_TABLE_DEPTH));
    assign tab_bad     = ({1'b0, tab_idx} >= cfg.pagetab_entries)
                      || ({1'b0, tab_idx} >= PAGE_CNT_W'(PAGE_TABLE_DEPTH));
    assign dir_rd_addr = dir_idx[PAGE_AW-1:0];
    assign tab_rd_addr = tab_idx[PAGE_AW-1:0];

    // Sequencer for loads and translates: descriptor read, limit check and add, page walk, result.
    always_comb
    begin
        state_next  = state_reg;
        local_next  = local_reg;
        offset_next = offset_reg;
        lin_next    = lin_reg;
        phys_next   = phys_reg;
        status_next = status_reg;
        out_load    = 1'b0;
        q_pop       = 1'b0;
        g_we = 1'b0; l_we = 1'b0; d_we = 1'b0; p_we = 1'b0;
        g_re = 1'b0; l_re = 1'b0; d_re = 1'b0; p_re = 1'b0;
        case (state_reg)
            BK_IDLE:
            begin
                if (q_valid)
                begin
                    if (q_cmd.kind == K_TRANSLATE && q_cmd.early == ST_OK)
                    begin
                        q_pop       = 1'b1;
                        g_re        = !q_cmd.is_local;
                        l_re        = q_cmd.is_local;
                        local_next  = q_cmd.is_local;
                        offset_next = q_cmd.offset;
                        state_next  = BK_DESC;
                    end
                    else if (out_free)
                    begin
                        q_pop       = 1'b1;
                        out_load    = 1'b1;
                        phys_next   = '0;
                        status_next = q_cmd.early;
                        g_we = (q_cmd.kind == K_WR_GLOBAL);
                        l_we = (q_cmd.kind == K_WR_LOCAL);
                        d_we = (q_cmd.kind == K_WR_DIR);
                        p_we = (q_cmd.kind == K_WR_PTE);
                    end
                end
            end
            BK_DESC:
            begin
                lin_next = lin_sum;
                if (!desc[47] || over_limit)
                begin
                    if (out_free)
                    begin
                        out_load    = 1'b1;
                        phys_next   = '0;
                        status_next = !desc[47] ? ST_ABSENT : ST_LIMIT;
                        state_next  = BK_IDLE;
                    end
                end
                else
                begin
                    state_next = BK_PAGE;
                end
            end
            BK_PAGE:
            begin
                if (dir_bad || tab_bad)
                begin
                    if (out_free)
                    begin
                        out_load    = 1'b1;
                        phys_next   = '0;
                        status_next = ST_NOPAGE;
                        state_next  = BK_IDLE;
                    end
                end
                else
                begin
                    d_re       = 1'b1;
                    p_re       = 1'b1;
                    state_next = BK_WALK;
                end
            end
            BK_WALK:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = BK_IDLE;
                    if (!d_rdata || !p_rdata[0])
                    begin
                        phys_next   = '0;
                        status_next = ST_PAGE_ABSENT;
                    end
                    else
                    begin
                        phys_next   = {p_rdata[PTE_W-1:1], lin_reg[11:0]};
                        status_next = ST_OK;
                    end
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // Output register: loaded by the sequencer, cleared when taken.
    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        local_reg  <= local_next;
        offset_reg <= offset_next;
        lin_reg    <= lin_next;
        phys_reg   <= phys_next;
        status_reg <= status_next;
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.phys_addr = phys_reg;
    assign rsp.status    = status_reg;

    // Table memories.
    spt_ram #(
        .DATA_WIDTH (DATA_W),
        .DEPTH      (SEG_TABLE_DEPTH)
    ) u_global_ram (
        .clk     (clk),
        .wr_en   (g_we),
        .wr_addr (seg_wr_addr),
        .wr_data (q_cmd.data),
        .rd_en   (g_re),
        .rd_addr (seg_rd_addr),
        .rd_data (g_rdata)
    );

    spt_ram #(
        .DATA_WIDTH (DATA_W),
        .DEPTH      (SEG_TABLE_DEPTH)
    ) u_local_ram (
        .clk     (clk),
        .wr_en   (l_we),
        .wr_addr (seg_wr_addr),
        .wr_data (q_cmd.data),
        .rd_en   (l_re),
        .rd_addr (seg_rd_addr),
        .rd_data (l_rdata)
    );

    spt_ram #(
        .DATA_WIDTH (1),
        .DEPTH      (PAGE_TABLE_DEPTH)
    ) u_dir_ram (
        .clk     (clk),
        .wr_en   (d_we),
        .wr_addr (page_wr_addr),
        .wr_data (q_cmd.data[0]),
        .rd_en   (d_re),
        .rd_addr (dir_rd_addr),
        .rd_data (d_rdata)
    );

    spt_ram #(
        .DATA_WIDTH (PTE_W),
        .DEPTH      (PAGE_TABLE_DEPTH)
    ) u_pte_ram (
        .clk     (clk),
        .wr_en   (p_we),
        .wr_addr (page_wr_addr),
        .wr_data (pte_wdata),
        .rd_en   (p_re),
        .rd_addr (tab_rd_addr),
        .rd_data (p_rdata)
    );
endmodule

// ===== hdl/segment_page_translate_unit.sv =====
`timescale 1ns / 1ps

// Segment and page address translation unit.
// Requests arrive on req_ch as valid/ready words: an action code selects a
// translate or a load into the global or local segment table, the page
// directory or the page table. Every request word yields exactly one response
// word on rsp_ch (physical address and status), in request order.
// The table counts are set through the cfg_we/cfg_index/cfg_data write port;
// the user must write them only while the unit is idle; the block does not enforce it.
// A front end classifies each word and runs the selector checks; a two-entry
// queue feeds the back end, which owns the table memories.
// A load, or a translate that fails on the selector, passes the queue and the
// response register; a full translate also passes the descriptor read, the limit
// check and base add, and the page table read. Loads go one per cycle while the
// receiver takes each response; a translate holds the back end until it is done.
// Reset clears the counts, the queue and the response register; the tables
// are not cleared and must be loaded before use.
// When the receiver stalls the response is held, the back end waits, and
// req_ch keeps accepting until the queue is full.
module segment_page_translate_unit #(
    parameter int SEG_TABLE_DEPTH  = spt_pkg::SEG_TABLE_DEPTH_DEF,
    parameter int PAGE_TABLE_DEPTH = spt_pkg::PAGE_TABLE_DEPTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [spt_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [spt_pkg::CFG_DATA_W-1:0]   cfg_data,
    spt_req_if.sink                          req_ch,
    spt_rsp_if.source                        rsp_ch
);
    import spt_pkg::*;

    cfg_t cfg_reg;
    logic q_full;
    logic q_push;
    logic q_pop;
    logic q_valid;
    cmd_t push_cmd;
    cmd_t head_cmd;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_GLOBAL_ENTRIES:    cfg_reg.global_entries    <= cfg_data[SEG_CNT_W-1:0];
                CFG_LOCAL_ENTRIES:     cfg_reg.local_entries     <= cfg_data[SEG_CNT_W-1:0];
                CFG_DIRECTORY_ENTRIES: cfg_reg.directory_entries <= cfg_data[PAGE_CNT_W-1:0];
                CFG_PAGETAB_ENTRIES:   cfg_reg.pagetab_entries   <= cfg_data[PAGE_CNT_W-1:0];
                default:               cfg_reg <= cfg_reg;
            endcase
        end
    end

    spt_front #(
        .SEG_TABLE_DEPTH  (SEG_TABLE_DEPTH),
        .PAGE_TABLE_DEPTH (PAGE_TABLE_DEPTH)
    ) u_front (
        .req    (req_ch),
        .cfg    (cfg_reg),
        .q_full (q_full),
        .push   (q_push),
        .cmd    (push_cmd)
    );

    spt_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_cmd   (push_cmd),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_cmd   (head_cmd)
    );

    spt_back #(
        .SEG_TABLE_DEPTH  (SEG_TABLE_DEPTH),
        .PAGE_TABLE_DEPTH (PAGE_TABLE_DEPTH)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .q_valid (q_valid),
        .q_cmd   (head_cmd),
        .q_pop   (q_pop),
        .rsp     (rsp_ch)
    );
endmodule

// ===== hdl/spt_checker.sv =====
`timescale 1ns / 1ps

module spt_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           rsp_valid,
    input  logic                           rsp_ready,
    input  logic [spt_pkg::ADDR_W-1:0]     rsp_phys_addr,
    input  logic [spt_pkg::STATUS_W-1:0]   rsp_status
);
    import spt_pkg::*;

    // No response is offered while reset is applied.
    a_no_rsp_in_reset: assert property (@(posedge clk)
        !rst_n |-> !rsp_valid)
        else $error("response offered during reset");

    // A failed translation never carries an address.
    a_fail_zero_addr: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_status != ST_OK) |-> (rsp_phys_addr == '0))
        else $error("nonzero address with error status");

    // Status is one of the defined codes.
    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp_status <= ST_PAGE_ABSENT))
        else $error("undefined status code");

    // A stalled response word holds until taken.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=>
            rsp_valid && $stable(rsp_phys_addr) && $stable(rsp_status))
        else $error("stalled response changed");
endmodule

bind segment_page_translate_unit spt_checker u_spt_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .rsp_valid     (rsp_ch.valid),
    .rsp_ready     (rsp_ch.ready),
    .rsp_phys_addr (rsp_ch.phys_addr),
    .rsp_status    (rsp_ch.status)
);

// ===== sim/tb_segment_page_translate_unit.sv =====
`timescale 1ns / 1ps

import spt_pkg::*;

// One expected response word: translated address and status.
typedef struct {
    logic [ADDR_W-1:0] phys;
    status_t           status;
} xlate_answer_t;

// Mirror of the translation tables and counts, plus the queue of owed responses.
class translate_scoreboard;
    logic [DATA_W-1:0] gdt [SEG_TABLE_DEPTH_DEF];
    logic [DATA_W-1:0] ldt [SEG_TABLE_DEPTH_DEF];
    bit                dir_on [PAGE_TABLE_DEPTH_DEF];
    logic [PTE_W-1:0]  ptab [PAGE_TABLE_DEPTH_DEF];
    bit                gdt_seen [SEG_TABLE_DEPTH_DEF];
    bit                ldt_seen [SEG_TABLE_DEPTH_DEF];
    bit                dir_seen [PAGE_TABLE_DEPTH_DEF];
    bit                pte_seen [PAGE_TABLE_DEPTH_DEF];
    int unsigned       global_cnt;
    int unsigned       local_cnt;
    int unsigned       dir_cnt;
    int unsigned       pte_cnt;
    xlate_answer_t     owed_responses [$];
    int unsigned       mismatches;

    function new();
        global_cnt = 0;
        local_cnt  = 0;
        dir_cnt    = 0;
        pte_cnt    = 0;
        mismatches = 0;
    endfunction

    function int unsigned clamp_cnt(int unsigned n, int unsigned depth);
        return (n > depth) ? depth : n;
    endfunction

    function int unsigned seg_count(logic is_local);
        return clamp_cnt(is_local ? local_cnt : global_cnt, SEG_TABLE_DEPTH_DEF);
    endfunction

    function int unsigned dir_limit();
        return clamp_cnt(dir_cnt, PAGE_TABLE_DEPTH_DEF);
    endfunction

    function int unsigned tab_limit();
        return clamp_cnt(pte_cnt, PAGE_TABLE_DEPTH_DEF);
    endfunction

    function bit seg_written(logic is_local, int unsigned idx);
        return is_local ? ldt_seen[idx] : gdt_seen[idx];
    endfunction

    function int unsigned outstanding();
        return owed_responses.size();
    endfunction

    // Count registers keep only their own width.
    function void set_count(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        case (idx)
            CFG_GLOBAL_ENTRIES:    global_cnt = val[SEG_CNT_W-1:0];
            CFG_LOCAL_ENTRIES:     local_cnt  = val[SEG_CNT_W-1:0];
            CFG_DIRECTORY_ENTRIES: dir_cnt    = val[PAGE_CNT_W-1:0];
            default:               pte_cnt    = val[PAGE_CNT_W-1:0];
        endcase
    endfunction

    // Segment check and page walk. When the walk would read an entry that was
    // never loaded, gap_act names the load that fills it and the status is moot.
    function status_t walk(input logic [SELECTOR_W-1:0] sel, input logic [OFFSET_W-1:0] offs,
                           output logic [ADDR_W-1:0] phys, output logic [ACTION_W-1:0] gap_act,
                           output int unsigned gap_slot);
        logic              is_local;
        int unsigned       idx;
        int unsigned       dir;
        int unsigned       tab;
        logic [DATA_W-1:0] d;
        logic [31:0]       limit;
        logic [31:0]       base;
        logic [31:0]       lin;
        phys     = '0;
        gap_act  = ACT_TRANSLATE;
        gap_slot = 0;
        is_local = sel[2];
        idx      = sel[15:3];
        if (!is_local && idx == 0)
            return ST_NULL;
        if (idx >= seg_count(is_local))
            return ST_NOSEG;
        if (!seg_written(is_local, idx))
        begin
            gap_act  = is_local ? ACT_WR_LOCAL : ACT_WR_GLOBAL;
            gap_slot = idx;
            return ST_OK;
        end
        d = is_local ? ldt[idx] : gdt[idx];
        if (!d[47])
            return ST_ABSENT;
        limit = {12'h000, d[51:48], d[15:0]};
        if (d[55])
            limit = {limit[19:0], 12'hFFF};
        if (offs > limit)
            return ST_LIMIT;
        base = {d[63:56], d[39:32], d[31:16]};
        lin  = base + offs;
        dir  = lin[31:22];
        tab  = lin[21:12];
        if (dir >= dir_limit() || tab >= tab_limit())
            return ST_NOPAGE;
        if (!dir_seen[dir])
        begin
            gap_act  = ACT_WR_DIR;
            gap_slot = dir;
            return ST_OK;
        end
        if (!pte_seen[tab])
        begin
            gap_act  = ACT_WR_PTE;
            gap_slot = tab;
            return ST_OK;
        end
        if (!dir_on[dir] || !ptab[tab][0])
            return ST_PAGE_ABSENT;
        phys = {ptab[tab][PTE_W-1:1], lin[11:0]};
        return ST_OK;
    endfunction

    // Apply an accepted request word and queue the response it owes.
    function void note_request(logic [ACTION_W-1:0] act, logic [SLOT_W-1:0] slot,
                               logic [DATA_W-1:0] data, logic [SELECTOR_W-1:0] sel,
                               logic [OFFSET_W-1:0] offs);
        xlate_answer_t     ans;
        logic [ADDR_W-1:0] phys;
        logic [ACTION_W-1:0] gap_act;
        int unsigned       gap_slot;
        ans.phys   = '0;
        ans.status = ST_OK;
        case (act)
            ACT_TRANSLATE:
            begin
                ans.status = walk(sel, offs, phys, gap_act, gap_slot);
                ans.phys   = phys;
            end
            ACT_WR_GLOBAL:
                if (slot < SEG_TABLE_DEPTH_DEF)
                begin
                    gdt[slot]      = data;
                    gdt_seen[slot] = 1'b1;
                end
            ACT_WR_LOCAL:
                if (slot < SEG_TABLE_DEPTH_DEF)
                begin
                    ldt[slot]      = data;
                    ldt_seen[slot] = 1'b1;
                end
            ACT_WR_DIR:
                if (slot < PAGE_TABLE_DEPTH_DEF)
                begin
                    dir_on[slot]   = data[0];
                    dir_seen[slot] = 1'b1;
                end
            ACT_WR_PTE:
                if (slot < PAGE_TABLE_DEPTH_DEF)
                begin
                    ptab[slot]     = {data[31:12], data[0]};
                    pte_seen[slot] = 1'b1;
                end
            default:
                ;
        endcase
        owed_responses.push_back(ans);
    endfunction

    // Compare a response word with the oldest owed one.
    function void check_response(logic [ADDR_W-1:0] phys, logic [STATUS_W-1:0] status);
        xlate_answer_t ans;
        if (owed_responses.size() == 0)
        begin
            $display("%0t: unexpected response word: phys_addr %h status %0d",
                     $time, phys, status);
            mismatches++;
            return;
        end
        ans = owed_responses.pop_front();
        if (phys !== ans.phys)
        begin
            $display("%0t: phys_addr mismatch: expected %h actual %h", $time, ans.phys, phys);
            mismatches++;
        end
        if (status !== ans.status)
        begin
            $display("%0t: status mismatch: expected %0d actual %0d", $time, ans.status, status);
            mismatches++;
        end
    endfunction
endclass

module tb_segment_page_translate_unit;

    localparam int unsigned RUN_LIMIT = 1000000;
    // Highest action code; codes above a page table load are ignored by the block.
    localparam logic [ACTION_W-1:0] ACT_TOP = 3'd7;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    spt_req_if req_ch();
    spt_rsp_if rsp_ch();

    translate_scoreboard sb;
    int unsigned send_idle_pct = 22;
    int unsigned rsp_stall_pct = 82;
    int unsigned cycles = 0;

    segment_page_translate_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req_ch    (req_ch),
        .rsp_ch    (rsp_ch)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog on the total run length.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= RUN_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Receiver: stalls at random at the current rate.
    initial
    begin
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
        end
    end

    // Every response word taken is checked against the mirror.
    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
            sb.check_response(rsp_ch.phys_addr, rsp_ch.status);
    end

    function automatic logic [DATA_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Segment descriptor with random filler around the chosen fields.
    function automatic logic [DATA_W-1:0] make_desc(input logic [31:0] base,
                                                    input logic [19:0] lim,
                                                    input logic present, input logic gran);
        logic [DATA_W-1:0] d;
        d        = rand64();
        d[15:0]  = lim[15:0];
        d[51:48] = lim[19:16];
        d[31:16] = base[15:0];
        d[39:32] = base[23:16];
        d[63:56] = base[31:24];
        d[47]    = present;
        d[55]    = gran;
        return d;
    endfunction

    // Page entry or directory word with random filler.
    function automatic logic [DATA_W-1:0] page_word(input logic [19:0] frame, input logic present);
        logic [DATA_W-1:0] d;
        d        = rand64();
        d[31:12] = frame;
        d[0]     = present;
        return d;
    endfunction

    // Present one request word and hold it until it is taken. Valid is left
    // high on return so that a following word goes out without a gap.
    task automatic drive_word(input logic [ACTION_W-1:0] act, input logic [SLOT_W-1:0] slot,
                              input logic [DATA_W-1:0] data, input logic [SELECTOR_W-1:0] sel,
                              input logic [OFFSET_W-1:0] offs);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.action      <= act;
        req_ch.entry_index <= slot;
        req_ch.entry_data  <= data;
        req_ch.selector    <= sel;
        req_ch.offset      <= offs;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        sb.note_request(act, slot, data, sel, offs);
        @(negedge clk);
    endtask

    // Translate, first loading any table entry the walk would read unwritten.
    task automatic translate_word(input logic [SELECTOR_W-1:0] sel,
                                  input logic [OFFSET_W-1:0] offs);
        logic [ADDR_W-1:0]   phys;
        logic [ACTION_W-1:0] gap_act;
        int unsigned         gap_slot;
        void'(sb.walk(sel, offs, phys, gap_act, gap_slot));
        while (gap_act != ACT_TRANSLATE)
        begin
            drive_word(gap_act, gap_slot[SLOT_W-1:0], rand64(), $urandom, $urandom);
            void'(sb.walk(sel, offs, phys, gap_act, gap_slot));
        end
        drive_word(ACT_TRANSLATE, $urandom, rand64(), sel, offs);
    endtask

    // Stop sending until every owed response word has come back.
    task automatic drain();
        req_ch.valid <= 1'b0;
        do
            @(negedge clk);
        while (sb.outstanding() != 0);
    endtask

    // Write all four count registers, one per cycle.
    task automatic write_counts(input int unsigned g, input int unsigned l,
                                input int unsigned d, input int unsigned p);
        logic [CFG_DATA_W-1:0] vals [4];
        logic [CFG_INDEX_W-1:0] idx [4];
        vals[0] = g;
        vals[1] = l;
        vals[2] = d;
        vals[3] = p;
        idx[0]  = CFG_GLOBAL_ENTRIES;
        idx[1]  = CFG_LOCAL_ENTRIES;
        idx[2]  = CFG_DIRECTORY_ENTRIES;
        idx[3]  = CFG_PAGETAB_ENTRIES;
        for (int i = 0; i < 4; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= vals[i];
            sb.set_count(idx[i], vals[i]);
            @(negedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    // Usually a descriptor load and page loads, then a translate that mostly walks through.
    task automatic wellformed_translate();
        logic              is_local;
        int unsigned       cnt;
        int unsigned       idx;
        int unsigned       dcnt;
        int unsigned       pcnt;
        logic [19:0]       lim;
        logic              gran;
        longint unsigned   eff;
        longint unsigned   offl;
        int unsigned       r;
        logic [31:0]       lin;
        logic [31:0]       offs;
        logic [SELECTOR_W-1:0] sel;
        is_local = $urandom_range(1);
        cnt      = sb.seg_count(is_local);
        if (cnt <= (is_local ? 0 : 1))
        begin
            translate_word($urandom, $urandom);
            return;
        end
        idx = $urandom_range(cnt - 1, is_local ? 0 : 1);
        sel = {idx[12:0], is_local, 2'($urandom)};
        if ($urandom_range(99) < 60 || !sb.seg_written(is_local, idx))
        begin
            gran = $urandom_range(1);
            case ($urandom_range(2))
                0:       lim = $urandom_range(15);
                1:       lim = $urandom;
                default: lim = 20'hFFFFF;
            endcase
            eff  = gran ? {lim, 12'hFFF} : lim;
            dcnt = sb.dir_limit();
            pcnt = sb.tab_limit();
            if (dcnt > 0 && pcnt > 0 && $urandom_range(9) != 0)
                lin = {10'($urandom_range(dcnt - 1)), 10'($urandom_range(pcnt - 1)),
                       12'($urandom)};
            else
                lin = $urandom;
            // Mostly inside the limit, sometimes exactly at it or past it.
            r = $urandom_range(99);
            if (r < 10)
                offl = eff;
            else if (r < 25 && eff < 64'hFFFF_FFFF)
                offl = eff + 1 + ({$urandom} % (64'hFFFF_FFFF - eff));
            else
                offl = {$urandom} % (eff + 1);
            offs = offl[31:0];
            drive_word(is_local ? ACT_WR_LOCAL : ACT_WR_GLOBAL, idx[SLOT_W-1:0],
                       make_desc(lin - offs, lim, $urandom_range(9) != 0, gran),
                       $urandom, $urandom);
            if (lin[31:22] < dcnt && lin[21:12] < pcnt)
            begin
                if ($urandom_range(99) < 70)
                    drive_word(ACT_WR_PTE, lin[21:12],
                               page_word($urandom, $urandom_range(9) != 0), $urandom, $urandom);
                if ($urandom_range(99) < 50)
                    drive_word(ACT_WR_DIR, lin[31:22],
                               page_word($urandom, $urandom_range(9) != 0), $urandom, $urandom);
            end
        end
        else
            offs = $urandom_range(1) ? $urandom : $urandom_range(4095);
        translate_word(sel, offs);
    endtask

    // One random stimulus item.
    task automatic random_item();
        int unsigned r;
        logic [SLOT_W-1:0] slot;
        r = $urandom_range(99);
        if (r < 50)
            wellformed_translate();
        else if (r < 60)
            translate_word($urandom, $urandom);
        else if (r < 68)
            translate_word({10'($urandom_range(511)), 3'($urandom)}, $urandom);
        else if (r < 93)
        begin
            slot = $urandom_range(1) ? 10'($urandom_range(255)) : 10'($urandom);
            drive_word($urandom_range(ACT_WR_PTE, ACT_WR_GLOBAL), slot, rand64(),
                       $urandom, $urandom);
        end
        else
            drive_word($urandom_range(ACT_TOP, ACT_WR_PTE + 1), $urandom, rand64(),
                       $urandom, $urandom);
    endtask

    // Drain, let the back end settle, set new counts and run random items.
    task automatic run_phase(input int unsigned g, input int unsigned l,
                             input int unsigned d, input int unsigned p,
                             input int unsigned items, input bit mid_drain);
        drain();
        repeat (8) @(negedge clk);
        write_counts(g, l, d, p);
        for (int unsigned i = 0; i < items; i++)
        begin
            if (mid_drain && i == items / 2)
                drain();
            random_item();
        end
    endtask

    // Each check and corner of the walk at least once, with known tables.
    task automatic directed_items();
        drive_word(ACT_WR_GLOBAL, 10'd1, make_desc(32'h0000_0000, 20'h00FFF, 1'b1, 1'b0),
                   16'hFFFF, 32'hFFFF_FFFF);
        drive_word(ACT_WR_GLOBAL, 10'd2, make_desc(32'h0000_0000, 20'hFFFFF, 1'b0, 1'b0),
                   16'h0000, 32'h0000_0000);
        drive_word(ACT_WR_GLOBAL, 10'd3, make_desc(32'hFFFF_F000, 20'hFFFFF, 1'b1, 1'b1),
                   16'h5555, 32'hAAAA_AAAA);
        drive_word(ACT_WR_DIR, 10'd0, page_word($urandom, 1'b1), $urandom, $urandom);
        drive_word(ACT_WR_DIR, 10'd1, page_word($urandom, 1'b0), $urandom, $urandom);
        drive_word(ACT_WR_PTE, 10'd0, page_word(20'hFFFFF, 1'b1), $urandom, $urandom);
        drive_word(ACT_WR_PTE, 10'd1, page_word(20'h00001, 1'b0), $urandom, $urandom);
        // Null selector, with and without requested privilege bits.
        translate_word(16'h0000, 32'h0000_0000);
        translate_word(16'h0003, 32'h0000_0010);
        // Small segment: inside, at and past its limit.
        translate_word(16'h0008, 32'h0000_0123);
        translate_word(16'h0008, 32'h0000_0FFF);
        translate_word(16'h0008, 32'h0000_1000);
        // Index past the local count and the largest global index.
        translate_word(16'h0044, 32'h0000_0000);
        translate_word(16'hFFF8, 32'hFFFF_FFFF);
        // Segment not present.
        translate_word(16'h0010, 32'h0000_0000);
        // Page-granular segment whose base plus offset wraps past 32 bits.
        translate_word(16'h0018, 32'h0000_1010);
        // Directory slot at the directory count, one past the last valid slot.
        translate_word(16'h0018, 32'h0000_0000);
        // Page entry absent, then directory entry absent.
        translate_word(16'h0018, 32'h0000_2000);
        translate_word(16'h0018, 32'h0040_1000);
        // Loads to slots past the table depth are dropped.
        drive_word(ACT_WR_GLOBAL, 10'h3FF, rand64(), $urandom, $urandom);
        drive_word(ACT_WR_LOCAL, 10'd256, rand64(), $urandom, $urandom);
        // Unused action codes.
        for (int a = ACT_WR_PTE + 1; a <= ACT_TOP; a++)
            drive_word(ACTION_W'(a), $urandom, rand64(), $urandom, $urandom);
    endtask

    // Main sequence.
    initial
    begin
        sb = new();
        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_index          = '0;
        cfg_data           = '0;
        req_ch.valid       = 1'b0;
        req_ch.action      = ACT_TRANSLATE;
        req_ch.entry_index = '0;
        req_ch.entry_data  = '0;
        req_ch.selector    = '0;
        req_ch.offset      = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Sender mostly busy, receiver mostly stalled.
        send_idle_pct = 22;
        rsp_stall_pct = 82;
        write_counts(8, 8, 1023, 1024);
        directed_items();
        run_phase(256, 256, 1024, 1024, 125, 1'b1);
        run_phase(0, 0, 0, 0, 40, 1'b0);

        // Sender mostly idle, receiver mostly ready.
        send_idle_pct = 82;
        rsp_stall_pct = 22;
        run_phase(511, 17, 2047, 64, 95, 1'b0);
        run_phase(3, 200, 5, 1000, 95, 1'b0);

        // Full rate on both sides.
        send_idle_pct = 0;
        rsp_stall_pct = 0;
        run_phase(40, 40, 16, 16, 95, 1'b0);
        run_phase($urandom_range(300), $urandom_range(300), $urandom_range(1100),
                  $urandom_range(1100), 95, 1'b0);

        drain();
        repeat (10) @(negedge clk);
        if (sb.mismatches == 0 && sb.outstanding() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
